/* sv/linear_queue_with_reverse_assert.svh */
// assertion macros for the linear queue with reverse
// used by lqr_ctrl; expects clk and rst_n in the including scope
`ifndef LINEAR_QUEUE_WITH_REVERSE_ASSERT_SVH
`define LINEAR_QUEUE_WITH_REVERSE_ASSERT_SVH
`ifndef SYNTHESIS
`define LQR_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lqr assertion failed");
`define LQR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lqr assertion failed");
`else
`define LQR_ASSERT(name, prop)
`define LQR_ASSERT_NEXT(name, ante, cons)
`endif
`endif

/* sv/lqr_pkg.sv */
// shared types, codes and constants for the linear queue with reverse
// no dependencies
`timescale 1ns / 1ps

package lqr_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

    localparam logic [1:0] ACT_ENQ = 2'd0;
    localparam logic [1:0] ACT_DEQ = 2'd1;
    localparam logic [1:0] ACT_REV = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEQ,
        ST_SWAP_RD,
        ST_SWAP_WLO,
        ST_SWAP_WHI,
        ST_RESULT
    } lqr_state_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr_a;
        logic [IDX_W-1:0]  raddr_b;
    } lqr_mem_req_t;

    typedef struct packed {
        logic              valid;
        logic [1:0]        status;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
    } lqr_result_t;

    function automatic logic [CNT_W-1:0] lqr_count(
        input logic             occ,
        input logic [IDX_W-1:0] head,
        input logic [IDX_W-1:0] tail
    );
        logic [CNT_W-1:0] n;
        n = CNT_W'(tail) - CNT_W'(head) + CNT_W'(1);
        return occ ? n : '0;
    endfunction

endpackage

/* sv/lqr_ram.sv */
// slot storage: one write port, two registered read ports
// depends on lqr_pkg
`timescale 1ns / 1ps

module lqr_ram (
    input  logic                         clk,
    input  lqr_pkg::lqr_mem_req_t        req,
    output logic [lqr_pkg::DATA_W-1:0]   rd_a,
    output logic [lqr_pkg::DATA_W-1:0]   rd_b
);

    logic [lqr_pkg::DATA_W-1:0] slots_mem [lqr_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            slots_mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a <= slots_mem[req.raddr_a];
        rd_b <= slots_mem[req.raddr_b];
    end

endmodule

/* sv/lqr_ctrl.sv */
// queue sequencer: index registers, full/empty checks and the swap loop
// depends on lqr_pkg and linear_queue_with_reverse_assert.svh
`timescale 1ns / 1ps
`include "linear_queue_with_reverse_assert.svh"

module lqr_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        action,
    input  logic signed [lqr_pkg::DATA_W-1:0] value,
    input  logic [lqr_pkg::CNT_W-1:0]         capacity,
    output lqr_pkg::lqr_mem_req_t             mem,
    input  logic [lqr_pkg::DATA_W-1:0]        rd_a,
    input  logic [lqr_pkg::DATA_W-1:0]        rd_b,
    output lqr_pkg::lqr_result_t              res,
    input  logic                              res_take
);

    lqr_pkg::lqr_state_t state_reg, state_next;

    logic [lqr_pkg::IDX_W-1:0]  head_reg, head_next;
    logic [lqr_pkg::IDX_W-1:0]  tail_reg, tail_next;
    logic                       occ_reg, occ_next;
    logic [lqr_pkg::IDX_W-1:0]  lo_reg, lo_next;
    logic [lqr_pkg::IDX_W-1:0]  hi_reg, hi_next;
    logic [lqr_pkg::DATA_W-1:0] tmp_reg, tmp_next;
    logic [1:0]                 res_status_reg, res_status_next;
    logic [lqr_pkg::DATA_W-1:0] res_data_reg, res_data_next;

    logic                       in_fire;
    logic [lqr_pkg::CNT_W-1:0]  cap_eff;
    logic                       full;
    logic [lqr_pkg::CNT_W-1:0]  enq_idx;
    logic                       swap_more;

    assign in_fire = in_valid && (state_reg == lqr_pkg::ST_IDLE);
    assign cap_eff = (capacity > lqr_pkg::CNT_W'(lqr_pkg::DEPTH))
                     ? lqr_pkg::CNT_W'(lqr_pkg::DEPTH) : capacity;
    assign full    = (cap_eff == '0)
                     || (occ_reg && (lqr_pkg::CNT_W'(tail_reg) >= cap_eff - 1'b1));
    assign enq_idx = occ_reg ? lqr_pkg::CNT_W'(tail_reg) + 1'b1 : '0;
    assign swap_more = (lqr_pkg::CNT_W'(lo_reg) + lqr_pkg::CNT_W'(2))
                       < lqr_pkg::CNT_W'(hi_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lqr_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (action == lqr_pkg::ACT_DEQ && occ_reg)
                    begin
                        state_next = lqr_pkg::ST_DEQ;
                    end
                    else if (action == lqr_pkg::ACT_REV && occ_reg && head_reg < tail_reg)
                    begin
                        state_next = lqr_pkg::ST_SWAP_RD;
                    end
                    else
                    begin
                        state_next = lqr_pkg::ST_RESULT;
                    end
                end
            end
            lqr_pkg::ST_DEQ:      state_next = lqr_pkg::ST_RESULT;
            lqr_pkg::ST_SWAP_RD:  state_next = lqr_pkg::ST_SWAP_WLO;
            lqr_pkg::ST_SWAP_WLO: state_next = lqr_pkg::ST_SWAP_WHI;
            lqr_pkg::ST_SWAP_WHI:
            begin
                state_next = swap_more ? lqr_pkg::ST_SWAP_RD : lqr_pkg::ST_RESULT;
            end
            lqr_pkg::ST_RESULT:
            begin
                if (res_take)
                begin
                    state_next = lqr_pkg::ST_IDLE;
                end
            end
            default: state_next = lqr_pkg::ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb
    begin
        in_ready     = (state_reg == lqr_pkg::ST_IDLE);
        res.valid    = (state_reg == lqr_pkg::ST_RESULT);
        res.status   = res_status_reg;
        res.data     = res_data_reg;
        res.count    = lqr_pkg::lqr_count(occ_reg, head_reg, tail_reg);
    end

    // indexes, memory requests and result fields
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        occ_next        = occ_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        tmp_next        = tmp_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        mem.raddr_a     = (state_reg == lqr_pkg::ST_IDLE) ? head_reg : lo_reg;
        mem.raddr_b     = hi_reg;
        mem.we          = 1'b0;
        mem.waddr       = lo_reg;
        mem.wdata       = rd_b;
        unique case (state_reg)
            lqr_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_status_next = lqr_pkg::STAT_OK;
                    res_data_next   = '0;
                    case (action)
                        lqr_pkg::ACT_ENQ:
                        begin
                            if (full || enq_idx >= lqr_pkg::CNT_W'(lqr_pkg::DEPTH))
                            begin
                                res_status_next = lqr_pkg::STAT_FULL;
                            end
                            else
                            begin
                                mem.we    = 1'b1;
                                mem.waddr = enq_idx[lqr_pkg::IDX_W-1:0];
                                mem.wdata = value;
                                tail_next = enq_idx[lqr_pkg::IDX_W-1:0];
                                head_next = occ_reg ? head_reg : '0;
                                occ_next  = 1'b1;
                            end
                        end
                        lqr_pkg::ACT_DEQ:
                        begin
                            if (!occ_reg)
                            begin
                                res_status_next = lqr_pkg::STAT_EMPTY;
                            end
                            else if (head_reg >= tail_reg)
                            begin
                                head_next = '0;
                                tail_next = '0;
                                occ_next  = 1'b0;
                            end
                            else
                            begin
                                head_next = head_reg + 1'b1;
                            end
                        end
                        lqr_pkg::ACT_REV:
                        begin
                            lo_next = head_reg;
                            hi_next = tail_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            lqr_pkg::ST_DEQ:
            begin
                res_data_next = rd_a;
            end
            lqr_pkg::ST_SWAP_RD:
            begin
            end
            lqr_pkg::ST_SWAP_WLO:
            begin
                mem.we    = 1'b1;
                mem.waddr = lo_reg;
                mem.wdata = rd_b;
                tmp_next  = rd_a;
            end
            lqr_pkg::ST_SWAP_WHI:
            begin
                mem.we    = 1'b1;
                mem.waddr = hi_reg;
                mem.wdata = tmp_reg;
                lo_next   = lo_reg + 1'b1;
                hi_next   = hi_reg - 1'b1;
            end
            lqr_pkg::ST_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lqr_pkg::ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            occ_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        tmp_reg        <= tmp_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
    end

    `LQR_ASSERT(a_head_le_tail, occ_reg |-> (head_reg <= tail_reg))
    `LQR_ASSERT(a_empty_at_start, !occ_reg |-> (head_reg == '0 && tail_reg == '0))
    `LQR_ASSERT(a_swap_order,
        (state_reg == lqr_pkg::ST_SWAP_RD || state_reg == lqr_pkg::ST_SWAP_WLO
         || state_reg == lqr_pkg::ST_SWAP_WHI) |-> (lo_reg < hi_reg))
    `LQR_ASSERT(a_no_write_on_read,
        (state_reg == lqr_pkg::ST_SWAP_RD || state_reg == lqr_pkg::ST_DEQ
         || state_reg == lqr_pkg::ST_RESULT) |-> !mem.we)
    `LQR_ASSERT_NEXT(a_deq_fetch, in_fire && action == lqr_pkg::ACT_DEQ && occ_reg,
        state_reg == lqr_pkg::ST_DEQ)

endmodule

/* sv/linear_queue_with_reverse.sv */
// Linear (non-circular) queue of signed 32-bit words with enqueue, dequeue
// and in-place reverse. One item is taken at a time: a dequeue makes one
// registered read of the slot memory (none on an empty queue), and a reverse
// swaps pairs from both ends inward; each swap reads both ends and then
// writes them back one after the other through the single write port of the
// slot memory. A result waits in its own output register, so the input side
// is free again once the result has moved there. The queue reports full once
// the tail reaches capacity - 1 and only restarts at slot 0 when it empties.
// Capacity sits at byte address 0 of the APB port; the user must write it only
// while the block is idle, and the block itself does not enforce this.
// depends on lqr_pkg, lqr_ram and lqr_ctrl
`timescale 1ns / 1ps

module linear_queue_with_reverse (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        action,
    input  logic signed [lqr_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic signed [lqr_pkg::DATA_W-1:0] data,
    output logic [lqr_pkg::CNT_W-1:0]         count,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lqr_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [lqr_pkg::CNT_W-1:0]  capacity_reg, capacity_next;
    logic                       out_valid_reg, out_valid_next;
    logic [1:0]                 status_reg, status_next;
    logic [lqr_pkg::DATA_W-1:0] data_reg, data_next;
    logic [lqr_pkg::CNT_W-1:0]  count_reg, count_next;

    lqr_pkg::lqr_mem_req_t      mem;
    lqr_pkg::lqr_result_t       res;
    logic [lqr_pkg::DATA_W-1:0] rd_a;
    logic [lqr_pkg::DATA_W-1:0] rd_b;
    logic                       res_take;
    logic                       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    // register file
    always_comb
    begin
        capacity_next = capacity_reg;
        if (psel && penable && pwrite && pready && reg_sel == lqr_pkg::REG_CAPACITY)
        begin
            capacity_next = pwdata[lqr_pkg::CNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            lqr_pkg::REG_CAPACITY: prdata = 32'(capacity_reg);
            default:               prdata = '0;
        endcase
    end

    // output register
    assign res_take = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        count_next     = count_reg;
        if (res_take)
        begin
            out_valid_next = res.valid;
            if (res.valid)
            begin
                status_next = res.status;
                data_next   = res.data;
                count_next  = res.count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= lqr_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            capacity_reg  <= capacity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        data_reg   <= data_next;
        count_reg  <= count_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data      = data_reg;
    assign count     = count_reg;

    lqr_ram u_ram (
        .clk  (clk),
        .req  (mem),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    lqr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .value    (value),
        .capacity (capacity_reg),
        .mem      (mem),
        .rd_a     (rd_a),
        .rd_b     (rd_b),
        .res      (res),
        .res_take (res_take)
    );

endmodule
